### src/lsf_pkg.sv
// Shared types, constants and helpers for the LPC synthesis filter.
package lsf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_COUNT = 16;
    localparam int PACK_W     = 64;
    localparam int PACK_COUNT = 4;
    localparam int ORDER_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + $clog2(COEF_COUNT);
    localparam int FRAC_BITS  = 12;
    localparam int TAP_W      = 6;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd4;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;

    typedef logic [PACK_COUNT-1:0][PACK_W-1:0] coef_bank_t;

    // History cell control
    typedef struct packed {
        logic rotate;   // take right neighbor (ring rotation)
        logic push;     // take left neighbor (new sample enters at cell 0)
    } cell_ctrl_t;

    // Multiply-accumulate control
    typedef struct packed {
        logic clear;    // zero product and accumulator
        logic mul_en;   // tap in use this cycle
        logic acc_en;   // fold registered product into accumulator
    } mac_ctrl_t;

    function automatic logic signed [COEF_W-1:0] coef_at(coef_bank_t bank, logic [3:0] idx);
        logic [PACK_W-1:0] word;
        word = bank[idx[3:2]];
        return word[idx[1:0]*COEF_W +: COEF_W];
    endfunction

endpackage

### src/lpc_synthesis_filter_core.sv
// Top level of the all-pole LPC synthesis filter: control, cell chain, MAC.
//
// Usage
//   Input channel (in_valid/in_ready, excitation, subframe_end): one transfer
//   per excitation sample. Output channel (out_valid/out_ready, synth_sample,
//   subframe_last): one transfer per input sample, in order.
//   Configuration: cfg_we/cfg_index/cfg_data, write-only, taken at any edge
//   with cfg_we high; write only while the filter is idle. Indexes above 4
//   are ignored.
// Operation
//   The history sits in a ring of MAX_ORDER cells that rotates once per
//   sample past a single shared 16x16 multiplier. After the input transfer
//   come the rotate/accumulate steps (the last drains the product register),
//   then a round/saturate/push step that sets out_valid. A new item is taken
//   only in the idle state, after the previous item has been pushed.
// Reset: history cleared, order = 16, coefficients zero, channels empty.
// Backpressure: the result sits in an output register; the next item is
//   accepted and computed meanwhile, and stalls in its final cycle only if
//   the previous result has still not been taken.
module lpc_synthesis_filter_core
    import lsf_pkg::*;
#(
    parameter int MAX_ORDER = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] excitation,
    input  logic                       subframe_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] synth_sample,
    output logic                       subframe_last,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [PACK_W-1:0]          cfg_data
);

    localparam int CNT_W   = $clog2(MAX_ORDER + 1);
    localparam int TAP_CAP = (MAX_ORDER < COEF_COUNT) ? MAX_ORDER : COEF_COUNT;
    localparam int RND_W   = ACC_W - FRAC_BITS;
    localparam int Y_W     = RND_W + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // ---------------- configuration registers ----------------
    logic [ORDER_W-1:0] order_reg;
    coef_bank_t         coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
            coef_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORDER:  order_reg   <= cfg_data[ORDER_W-1:0];
                REG_COEF_A: coef_reg[0] <= cfg_data;
                REG_COEF_B: coef_reg[1] <= cfg_data;
                REG_COEF_C: coef_reg[2] <= cfg_data;
                REG_COEF_D: coef_reg[3] <= cfg_data;
                default:    ;   // out-of-range index: dropped
            endcase
        end
    end

    // taps = min(order, MAX_ORDER, 16)
    logic [TAP_W-1:0] taps;
    assign taps = ({1'b0, order_reg} > TAP_W'(TAP_CAP)) ? TAP_W'(TAP_CAP)
                                                        : {1'b0, order_reg};

    // ---------------- sequencer ----------------
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] exc_reg;
    logic             sf_reg;
    logic             out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic             out_last_reg;

    logic in_xfer;
    logic out_free;
    logic finish_go;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign finish_go = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_xfer)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cnt_reg == CNT_W'(MAX_ORDER))
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            exc_reg <= excitation;
            sf_reg  <= subframe_end;
        end
    end

    // ---------------- history ring ----------------
    logic       rotating;
    cell_ctrl_t cell_ctrl;
    logic signed [SAMPLE_W-1:0] hist [MAX_ORDER];
    logic signed [SAMPLE_W-1:0] y_sat;

    assign rotating         = (state_reg == ST_RUN) && (cnt_reg != CNT_W'(MAX_ORDER));
    assign cell_ctrl.rotate = rotating;
    assign cell_ctrl.push   = finish_go;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ORDER; gi++)
        begin : g_cell
            localparam int NEXT = (gi + 1) % MAX_ORDER;
            logic signed [SAMPLE_W-1:0] left_val;
            if (gi == 0)
            begin : g_head
                assign left_val = y_sat;
            end
            else
            begin : g_body
                assign left_val = hist[gi-1];
            end
            lsf_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .from_right (hist[NEXT]),
                .from_left  (left_val),
                .value      (hist[gi])
            );
        end
    endgenerate

    // ---------------- multiply-accumulate ----------------
    // During rotation step k (counted from 0), cell 0 holds the (k+1)-th most recent output.
    mac_ctrl_t mac_ctrl;
    logic signed [ACC_W-1:0] acc;

    assign mac_ctrl.clear  = in_xfer;
    assign mac_ctrl.mul_en = rotating && (TAP_W'(cnt_reg) < taps);
    assign mac_ctrl.acc_en = (state_reg == ST_RUN);

    lsf_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (coef_at(coef_reg, 4'(cnt_reg))),
        .sample (hist[0]),
        .acc    (acc)
    );

    // ---------------- round, add excitation, saturate ----------------
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [RND_W-1:0] pred;
    logic signed [Y_W-1:0]   y_wide;

    assign acc_rnd = acc + ACC_W'(2048);
    assign pred    = RND_W'(acc_rnd >>> FRAC_BITS);
    assign y_wide  = Y_W'(pred) + Y_W'(exc_reg);

    always_comb
    begin
        priority if (y_wide > Y_W'(32767))
            y_sat = 16'sh7FFF;
        else if (y_wide < -Y_W'(32768))
            y_sat = 16'sh8000;
        else
            y_sat = y_wide[SAMPLE_W-1:0];
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish_go)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            out_sample_reg <= y_sat;
            out_last_reg   <= sf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign synth_sample  = out_sample_reg;
    assign subframe_last = out_last_reg;

    // ---------------- assertions ----------------
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_RUN) && (cnt_reg == '0))
        else $error("accepted item did not start a run");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= CNT_W'(MAX_ORDER)))
        else $error("tap counter out of range");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished item not presented");

    a_no_push_while_rotating: assert property (@(posedge clk) disable iff (!rst_n)
        !(cell_ctrl.push && cell_ctrl.rotate))
        else $error("history push during rotation");

endmodule

### src/lsf_cell.sv
// One history cell: holds a sample, rotates or shifts it along the chain.
module lsf_cell
    import lsf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] from_right,
    input  logic signed [SAMPLE_W-1:0] from_left,
    output logic signed [SAMPLE_W-1:0] value
);

    logic signed [SAMPLE_W-1:0] val_reg;
    logic signed [SAMPLE_W-1:0] val_next;

    always_comb
    begin
        priority if (ctrl.push)
            val_next = from_left;
        else if (ctrl.rotate)
            val_next = from_right;
        else
            val_next = val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            val_reg <= '0;
        else
            val_reg <= val_next;
    end

    assign value = val_reg;

endmodule

### src/lsf_mac.sv
// Shared multiply-accumulate: registered product, then wide accumulate.
module lsf_mac
    import lsf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        prod_next = '0;
        if (ctrl.mul_en && !ctrl.clear)
            prod_next = coef * sample;
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (ctrl.acc_en)
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### verif/lpc_synthesis_filter_core_test.sv
// Self-checking testbench for the LPC synthesis filter core.
module lpc_synthesis_filter_core_test;
    import lsf_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int HIST_DEPTH    = 16;              // MAX_ORDER of the instance
    localparam int SETTLE_CYCLES = HIST_DEPTH + 4;  // settling wait after the queue drains
    localparam int CYCLE_LIMIT   = 400000;          // watchdog bound on the whole simulation
    localparam int HOLD_CYCLES   = 300;             // long receiver hold-off
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 60;

    // One synthesized sample as it should leave the block
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } synth_result_t;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] excitation;
    logic                       subframe_end;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] synth_sample;
    logic                       subframe_last;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [PACK_W-1:0]          cfg_data;

    lpc_synthesis_filter_core #(
        .MAX_ORDER (HIST_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .excitation    (excitation),
        .subframe_end  (subframe_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .synth_sample  (synth_sample),
        .subframe_last (subframe_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    // Filter shadow: what the block should hold right now
    logic [ORDER_W-1:0]         order_shadow;
    logic [PACK_W-1:0]          coef_shadow [PACK_COUNT];
    logic signed [SAMPLE_W-1:0] hist_shadow [HIST_DEPTH];

    synth_result_t pending_synth[$];   // expected samples, oldest first
    synth_result_t next_synth;         // used by the output monitor
    int            fail_count  = 0;
    int            cycle_count = 0;
    bit            gaps_on     = 1'b0; // random idling on both sides
    int            hold_left   = 0;    // receiver hold-off requested by a test
    int            stall_left  = 0;

    // 10-unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------
    task automatic shadow_reset();
        order_shadow = ORDER_RESET;
        foreach (coef_shadow[i])
            coef_shadow[i] = '0;
        foreach (hist_shadow[i])
            hist_shadow[i] = '0;
    endtask

    // Runs the all-pole recursion for one excitation sample, updates the
    // shadow history and queues the sample the block must produce.
    task automatic synthesize_sample(input logic signed [SAMPLE_W-1:0] exc,
                                     input logic sfe);
        int                         taps;
        longint                     acc;
        longint                     pred;
        longint                     y;
        logic signed [COEF_W-1:0]   coef;
        synth_result_t              res;
        taps = (order_shadow > HIST_DEPTH) ? HIST_DEPTH : int'(order_shadow);
        if (taps > COEF_COUNT)
            taps = COEF_COUNT;
        acc = 0;
        for (int j = 0; j < taps; j++)
        begin
            coef = coef_shadow[j >> 2][(j & 3) * COEF_W +: COEF_W];
            acc += longint'(coef) * longint'(hist_shadow[j]);
        end
        // round half up, then drop the Q12 fraction (arithmetic shift = floor)
        pred = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        y = longint'(exc) + pred;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        for (int j = HIST_DEPTH - 1; j > 0; j--)
            hist_shadow[j] = hist_shadow[j - 1];
        hist_shadow[0] = y[SAMPLE_W-1:0];
        res.sample = y[SAMPLE_W-1:0];
        res.last   = sfe;
        pending_synth.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Register write: cfg_we high for one cycle, then dropped low again.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == REG_ORDER)
            order_shadow = val[ORDER_W-1:0];
        else if (idx >= REG_COEF_A && idx <= REG_COEF_D)
            coef_shadow[idx - REG_COEF_A] = val;
        // other indexes are dropped by the block
    endtask

    task automatic load_filter(input logic [ORDER_W-1:0] order,
                               input logic [PACK_W-1:0] pa, input logic [PACK_W-1:0] pb,
                               input logic [PACK_W-1:0] pc, input logic [PACK_W-1:0] pd);
        write_reg(REG_ORDER, PACK_W'(order));
        write_reg(REG_COEF_A, pa);
        write_reg(REG_COEF_B, pb);
        write_reg(REG_COEF_C, pc);
        write_reg(REG_COEF_D, pd);
    endtask

    // Offers one excitation sample and returns at the edge of its transfer.
    // Valid stays high afterwards so back-to-back items follow without a gap;
    // it only drops for an idle gap or when the phase drains.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] exc, input logic sfe);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        excitation   <= exc;
        subframe_end <= sfe;
        // inputs move only on rising edges, so ready seen at the falling
        // edge is what the next rising edge uses
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        synthesize_sample(exc, sfe);
    endtask

    // Drops valid and waits for every queued sample, then for the settling wait.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_synth.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when a test asks
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: a transfer seen at the falling edge completes at the
    // next rising edge; compare it with the oldest expectation.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_synth.size() == 0)
            begin
                $error("unexpected transfer: synth_sample %0d subframe_last %0b",
                       synth_sample, subframe_last);
                fail_count++;
            end
            else
            begin
                next_synth = pending_synth.pop_front();
                if (synth_sample !== next_synth.sample)
                begin
                    $error("synth_sample: expected %0d, got %0d",
                           next_synth.sample, synth_sample);
                    fail_count++;
                end
                if (subframe_last !== next_synth.last)
                begin
                    $error("subframe_last: expected %0b, got %0b",
                           next_synth.last, subframe_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [SAMPLE_W-1:0] rand_excitation();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1, 2:    return SAMPLE_W'($urandom_range(0, 600) - 300);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Four Q12 coefficients; small magnitudes keep the filter stable,
    // mag == 0 means fully random bits (usually saturating).
    function automatic logic [PACK_W-1:0] rand_coef_pack(input int mag);
        logic [PACK_W-1:0] word;
        for (int k = 0; k < 4; k++)
        begin
            if (mag == 0)
                word[k*COEF_W +: COEF_W] = COEF_W'($urandom);
            else
                word[k*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 2*mag) - mag);
        end
        return word;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset state: all coefficients zero, so output equals excitation.
    task automatic test_reset_passthrough();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd1, 1'b0);
        wait_drained();
    endtask

    // Order zero ignores even large coefficients.
    task automatic test_order_zero();
        load_filter(5'd0, 64'h7FFF_8000_1234_7FFF, 64'h8000_8000_8000_8000,
                    64'h7FFF_7FFF_7FFF_7FFF, 64'h0FFF_F001_4000_C000);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        wait_drained();
    endtask

    // Largest coefficients drive the sum past both rails.
    task automatic test_saturation();
        load_filter(5'd1, 64'h0000_0000_0000_7FFF, '0, '0, '0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        wait_drained();
        write_reg(REG_COEF_A, 64'h0000_0000_0000_8000);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b1);
        wait_drained();
    endtask

    // Half-way ties round toward plus infinity for both signs.
    task automatic test_rounding_ties();
        write_reg(REG_COEF_A, '0);
        send_sample(16'sd2048, 1'b0);
        wait_drained();
        write_reg(REG_COEF_A, 64'h0000_0000_0000_0001);
        send_sample(16'sd0, 1'b0);     // +2048/4096 -> +1
        send_sample(-16'sd2048, 1'b0); // prediction rounds to zero
        send_sample(16'sd0, 1'b1);     // -2048/4096 -> 0
        wait_drained();
    endtask

    // Order above the tap count clamps to all sixteen taps.
    task automatic test_order_overflow();
        load_filter(5'd31, 64'h0100_FF00_0200_0400, 64'h0080_FF80_0040_FFC0,
                    64'h0020_FFE0_0010_FFF0, 64'h0008_FFF8_0004_0800);
        send_sample(16'sd4000, 1'b0);
        send_sample(-16'sd3000, 1'b0);
        send_sample(16'sd0, 1'b1);
        wait_drained();
    endtask

    // Writes to unused indexes leave every register as it was.
    task automatic test_unused_index();
        write_reg(CFG_IDX_W'(5), '1);
        write_reg(CFG_IDX_W'(6), '0);
        write_reg(CFG_IDX_W'(7), 64'h8000_8000_8000_8000);
        send_sample(16'sd1234, 1'b0);
        send_sample(-16'sd4321, 1'b1);
        wait_drained();
    endtask

    // Random samples over a series of filter settings, extremes first.
    task automatic test_random_phases(input int phases, input int items, input bit gaps);
        logic [ORDER_W-1:0] order;
        int                 mag;
        gaps_on = gaps;
        for (int p = 0; p < phases; p++)
        begin
            case (p)
                0:       order = 5'd16;
                1:       order = 5'd1;
                2:       order = 5'd0;
                3:       order = 5'd31;
                default: order = ORDER_W'($urandom_range(0, 31));
            endcase
            mag = (p % 3 == 2) ? 0 : $urandom_range(64, 700);
            load_filter(order, rand_coef_pack(mag), rand_coef_pack(mag),
                        rand_coef_pack(mag), rand_coef_pack(mag));
            // subframes of random length; the mark must not disturb the filter
            for (int i = 0; i < items; i++)
                send_sample(rand_excitation(), $urandom_range(0, 9) == 0);
            wait_drained();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering;
    // the block must fill its output register and stall its input.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        load_filter(5'd16, rand_coef_pack(300), rand_coef_pack(300),
                    rand_coef_pack(300), rand_coef_pack(300));
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_sample(rand_excitation(), $urandom_range(0, 1));
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        excitation   = '0;
        subframe_end = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        shadow_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_passthrough();
        test_order_zero();
        test_saturation();
        test_rounding_ties();
        test_order_overflow();
        test_unused_index();
        test_random_phases(RAND_PHASES, PHASE_ITEMS, 1'b1);
        test_backpressure();
        // closing stretch with no idling on either side
        test_random_phases(1, PHASE_ITEMS, 1'b0);

        if (fail_count == 0 && pending_synth.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
